// ===== rtl/tcp_socket_table_with_port_alloc_top_defines.svh =====
// Assertion macros shared by the socket table RTL.
// Depends on nothing; the using module must have clk and rst_n in scope.
`ifndef TCP_SOCKET_TABLE_WITH_PORT_ALLOC_TOP_DEFINES_SVH
`define TCP_SOCKET_TABLE_WITH_PORT_ALLOC_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TCPST_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("socket table check failed");
`define TCPST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("socket table sequence check failed");
`else
`define TCPST_ASSERT_ALWAYS(label, expr)
`define TCPST_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/tcpst_pkg.sv =====
// Shared types, codes and constants of the socket table.
// Used by the controller, the datapath and the top level.
package tcpst_pkg;

    localparam int CONN_SLOTS_DEF = 64;
    localparam int PORT_SLOTS_DEF = 4096;

    localparam logic [15:0] RANGE_START_RST = 16'd1024;
    localparam logic [15:0] RANGE_END_RST   = 16'd5000;
    localparam logic [16:0] ANY_PORT        = 17'h1FFFF;
    localparam logic [6:0]  COUNT_MAX       = 7'd127;

    localparam logic [2:0] REQ_LOOKUP = 3'd0;
    localparam logic [2:0] REQ_INSERT = 3'd1;
    localparam logic [2:0] REQ_REKEY  = 3'd2;
    localparam logic [2:0] REQ_REMOVE = 3'd3;
    localparam logic [2:0] REQ_ALLOC  = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_IN_USE    = 2'd2;
    localparam logic [1:0] ST_EXHAUSTED = 2'd3;

    localparam logic [2:0] RES_OK     = 3'd0;
    localparam logic [2:0] RES_NF     = 3'd1;
    localparam logic [2:0] RES_DUP    = 3'd2;
    localparam logic [2:0] RES_EXH    = 3'd3;
    localparam logic [2:0] RES_LOOKUP = 3'd4;
    localparam logic [2:0] RES_GIVEN  = 3'd5;

    localparam logic CFG_RANGE_START = 1'b0;
    localparam logic CFG_RANGE_END   = 1'b1;

    typedef struct packed {
        logic [31:0] la;
        logic [31:0] ra;
        logic [15:0] lp;
        logic [16:0] rp;
    } ent_t;

    typedef struct packed {
        logic       load;
        logic       clr_step;
        logic       scan_start;
        logic       scan_issue;
        logic       slot_rd;
        logic       ent_lat;
        logic       ent_wr;
        logic       valid_set;
        logic       valid_clr;
        logic       cnt_rd;
        logic       cnt_wr;
        logic       alloc_init;
        logic       alloc_adv;
        logic       res_set;
        logic [2:0] res_kind;
    } cmd_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic       slot_ok;
        logic       slot_vld;
        logic       span_zero;
        logic       clr_done;
        logic       scan_last;
        logic       scan_done;
        logic       hit_exact;
        logic       cnt_ok;
        logic       alloc_end;
        logic       cand_direct;
        logic       cnt_zero;
        logic       out_free;
    } sts_t;

endpackage

// ===== rtl/tcpst_ram.sv =====
// Generic simple dual-port RAM with registered read data.
// Depends on nothing.
module tcpst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/tcpst_ctrl.sv =====
// Sequencing state machine of the socket table.
// Depends on tcpst_pkg and the assertion macro header.
`include "tcp_socket_table_with_port_alloc_top_defines.svh"
module tcpst_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  tcpst_pkg::sts_t sts,
    output tcpst_pkg::cmd_t cmd
);
    import tcpst_pkg::*;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DISP   = 4'd2;
    localparam logic [3:0] S_SCAN   = 4'd3;
    localparam logic [3:0] S_SLOT   = 4'd4;
    localparam logic [3:0] S_SLOTW  = 4'd5;
    localparam logic [3:0] S_CNTRD  = 4'd6;
    localparam logic [3:0] S_CNTWR  = 4'd7;
    localparam logic [3:0] S_AISSUE = 4'd8;
    localparam logic [3:0] S_ACHECK = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    logic [3:0] state_reg, state_next;
    logic [2:0] kind_reg, kind_next;
    logic       accept;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            kind_reg  <= RES_NF;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        cmd.res_kind = kind_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (sts.clr_done)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.clr_step = 1'b1;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                unique case (sts.req_type)
                    REQ_LOOKUP:
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_SCAN;
                    end
                    REQ_INSERT:
                    begin
                        if (!sts.slot_ok)
                        begin
                            kind_next  = RES_NF;
                            state_next = S_DONE;
                        end
                        else if (sts.slot_vld)
                        begin
                            kind_next  = RES_DUP;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end
                    REQ_REKEY, REQ_REMOVE:
                    begin
                        if (!sts.slot_vld)
                        begin
                            kind_next  = RES_NF;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cmd.slot_rd = 1'b1;
                            state_next  = S_SLOTW;
                        end
                    end
                    REQ_ALLOC:
                    begin
                        if (sts.span_zero)
                        begin
                            kind_next  = RES_EXH;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cmd.alloc_init = 1'b1;
                            state_next     = S_AISSUE;
                        end
                    end
                    default:
                    begin
                        kind_next  = RES_NF;
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SLOTW:
            begin
                cmd.ent_lat = 1'b1;
                if (sts.req_type == REQ_REKEY)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
                else
                begin
                    cmd.valid_clr = 1'b1;
                    state_next    = S_CNTRD;
                end
            end
            S_SCAN:
            begin
                cmd.scan_issue = !sts.scan_last;
                if (sts.scan_done)
                begin
                    if (sts.req_type == REQ_LOOKUP)
                    begin
                        kind_next  = RES_LOOKUP;
                        state_next = S_DONE;
                    end
                    else if (sts.hit_exact)
                    begin
                        kind_next  = RES_DUP;
                        state_next = S_DONE;
                    end
                    else if (sts.req_type == REQ_INSERT)
                    begin
                        cmd.ent_wr    = 1'b1;
                        cmd.valid_set = 1'b1;
                        state_next    = S_CNTRD;
                    end
                    else
                    begin
                        cmd.ent_wr = 1'b1;
                        kind_next  = RES_OK;
                        state_next = S_DONE;
                    end
                end
            end
            S_CNTRD:
            begin
                if (sts.cnt_ok)
                begin
                    cmd.cnt_rd = 1'b1;
                    state_next = S_CNTWR;
                end
                else
                begin
                    kind_next  = RES_OK;
                    state_next = S_DONE;
                end
            end
            S_CNTWR:
            begin
                cmd.cnt_wr = 1'b1;
                kind_next  = RES_OK;
                state_next = S_DONE;
            end
            S_AISSUE:
            begin
                if (sts.alloc_end)
                begin
                    kind_next  = RES_EXH;
                    state_next = S_DONE;
                end
                else if (sts.cand_direct)
                begin
                    kind_next  = RES_GIVEN;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.cnt_rd = 1'b1;
                    state_next = S_ACHECK;
                end
            end
            S_ACHECK:
            begin
                if (sts.cnt_zero)
                begin
                    kind_next  = RES_GIVEN;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.alloc_adv = 1'b1;
                    state_next    = S_AISSUE;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.res_set = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `TCPST_ASSERT_NEXT(a_accept_dispatch, accept, state_reg == S_DISP)
    `TCPST_ASSERT_ALWAYS(a_result_room, !cmd.res_set || sts.out_free)
    `TCPST_ASSERT_ALWAYS(a_no_scan_overrun, !cmd.scan_issue || !sts.scan_last)
    `TCPST_ASSERT_ALWAYS(a_clear_blocks, state_reg != S_CLEAR || in_stall)

endmodule

// ===== rtl/tcpst_dp.sv =====
// Datapath of the socket table: request registers, connection and port-count
// memories, the slot scan, the port search and the result register.
// Depends on tcpst_pkg and tcpst_ram.
module tcpst_dp #(
    parameter int CONN_SLOTS = 64,
    parameter int PORT_SLOTS = 4096
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic            cfg_index,
    input  logic [15:0]     cfg_data,
    input  logic [2:0]      req_type,
    input  logic [5:0]      conn_slot,
    input  logic [31:0]     local_addr,
    input  logic [31:0]     remote_addr,
    input  logic [15:0]     local_port,
    input  logic signed [16:0] remote_port,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [1:0]      status,
    output logic [5:0]      found_slot,
    output logic [15:0]     given_port,
    input  tcpst_pkg::cmd_t cmd,
    output tcpst_pkg::sts_t sts
);
    import tcpst_pkg::*;

    localparam int SW = $clog2(CONN_SLOTS);
    localparam int PW = $clog2(PORT_SLOTS);

    logic [2:0]  rq_type_reg;
    logic [5:0]  rq_slot_reg;
    logic [31:0] rq_la_reg, rq_ra_reg;
    logic [15:0] rq_lp_reg;
    logic [16:0] rq_rp_reg;
    logic [15:0] start_reg, end_reg, last_reg;
    logic [CONN_SLOTS-1:0] valid_reg;
    logic [15:0] ent_lp_reg;
    logic [SW:0] scan_idx_reg;
    logic        pend_reg;
    logic [SW-1:0] cmp_idx_reg;
    logic [3:0]  hit_reg;
    logic [SW-1:0] hit_slot_reg [4];
    logic [15:0] cand_reg, iter_reg;
    logic [PW:0] clr_idx_reg;
    logic        out_valid_reg;
    logic [1:0]  status_reg;
    logic [5:0]  found_reg;
    logic [15:0] given_reg;

    logic [SW-1:0] slot_addr;
    logic          slot_ok;
    ent_t          ent_rd, ent_wd;
    logic [SW-1:0] ent_raddr;
    logic [6:0]    cnt_rd_data, cnt_wd;
    logic [PW-1:0] cnt_raddr, cnt_waddr;
    logic          cnt_we;
    logic [15:0]   key_lp;
    logic [3:0]    match;
    logic          cmp_live;
    logic [15:0]   span, cand_off, upd_port, upd_off;
    logic [16:0]   last_inc, cand_inc;
    logic [15:0]   init_cand, adv_cand;
    logic [1:0]    lk_status;
    logic [SW-1:0] lk_slot;
    logic [1:0]    res_status;
    logic [5:0]    res_found;
    logic [15:0]   res_given;

    assign slot_addr = SW'(rq_slot_reg);
    assign slot_ok   = ({26'd0, rq_slot_reg} < 32'(CONN_SLOTS));
    assign key_lp    = (rq_type_reg == REQ_REKEY) ? ent_lp_reg : rq_lp_reg;

    assign ent_raddr = cmd.scan_issue ? scan_idx_reg[SW-1:0] : slot_addr;
    assign ent_wd    = '{la: rq_la_reg, ra: rq_ra_reg, lp: key_lp, rp: rq_rp_reg};

    tcpst_ram #(.WIDTH($bits(ent_t)), .DEPTH(CONN_SLOTS)) u_ent_ram (
        .clk   (clk),
        .we    (cmd.ent_wr),
        .waddr (slot_addr),
        .wdata (ent_wd),
        .raddr (ent_raddr),
        .rdata (ent_rd)
    );

    assign span      = (end_reg > start_reg) ? (end_reg - start_reg) : 16'd0;
    assign cand_off  = cand_reg - start_reg;
    assign upd_port  = (rq_type_reg == REQ_INSERT) ? rq_lp_reg : ent_lp_reg;
    assign upd_off   = upd_port - start_reg;
    assign last_inc  = {1'b0, last_reg} + 17'd1;
    assign cand_inc  = {1'b0, cand_reg} + 17'd1;
    assign init_cand = (last_inc >= {1'b0, end_reg} || last_inc < {1'b0, start_reg})
                       ? start_reg : last_inc[15:0];
    assign adv_cand  = (cand_inc >= {1'b0, end_reg}) ? start_reg : cand_inc[15:0];

    assign cnt_raddr = (rq_type_reg == REQ_ALLOC) ? cand_off[PW-1:0] : upd_off[PW-1:0];
    assign cnt_waddr = cmd.clr_step ? clr_idx_reg[PW-1:0] : upd_off[PW-1:0];

    always_comb
    begin
        cnt_we = 1'b0;
        cnt_wd = 7'd0;
        if (cmd.clr_step)
        begin
            cnt_we = 1'b1;
        end
        else if (cmd.cnt_wr)
        begin
            if (rq_type_reg == REQ_INSERT)
            begin
                cnt_we = (cnt_rd_data != COUNT_MAX);
                cnt_wd = cnt_rd_data + 7'd1;
            end
            else
            begin
                cnt_we = (cnt_rd_data != 7'd0);
                cnt_wd = cnt_rd_data - 7'd1;
            end
        end
    end

    tcpst_ram #(.WIDTH(7), .DEPTH(PORT_SLOTS)) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wd),
        .raddr (cnt_raddr),
        .rdata (cnt_rd_data)
    );

    assign cmp_live = pend_reg && valid_reg[cmp_idx_reg] &&
                      !(rq_type_reg == REQ_REKEY && cmp_idx_reg == slot_addr);

    always_comb
    begin
        match[0] = ent_rd.la == rq_la_reg && ent_rd.ra == rq_ra_reg &&
                   ent_rd.lp == key_lp && ent_rd.rp == rq_rp_reg;
        match[1] = ent_rd.la == 32'd0 && ent_rd.ra == rq_ra_reg &&
                   ent_rd.lp == key_lp && ent_rd.rp == rq_rp_reg;
        match[2] = ent_rd.la == rq_la_reg && ent_rd.ra == 32'd0 &&
                   ent_rd.lp == key_lp && ent_rd.rp == ANY_PORT;
        match[3] = ent_rd.la == 32'd0 && ent_rd.ra == 32'd0 &&
                   ent_rd.lp == key_lp && ent_rd.rp == ANY_PORT;
    end

    always_comb
    begin
        lk_status = ST_OK;
        lk_slot   = hit_slot_reg[3];
        if (hit_reg[0])
        begin
            lk_slot = hit_slot_reg[0];
        end
        else if (hit_reg[1])
        begin
            lk_slot = hit_slot_reg[1];
        end
        else if (hit_reg[2])
        begin
            lk_slot = hit_slot_reg[2];
        end
        else if (!hit_reg[3])
        begin
            lk_status = ST_NOT_FOUND;
        end
    end

    always_comb
    begin
        res_status = ST_OK;
        res_found  = 6'd0;
        res_given  = 16'd0;
        case (cmd.res_kind)
            RES_NF:     res_status = ST_NOT_FOUND;
            RES_DUP:    res_status = ST_IN_USE;
            RES_EXH:    res_status = ST_EXHAUSTED;
            RES_LOOKUP:
            begin
                res_status = lk_status;
                res_found  = (lk_status == ST_OK) ? 6'(lk_slot) : 6'd0;
            end
            RES_GIVEN:  res_given = cand_reg;
            default:    res_status = ST_OK;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rq_type_reg <= req_type;
            rq_slot_reg <= conn_slot;
            rq_la_reg   <= local_addr;
            rq_ra_reg   <= remote_addr;
            rq_lp_reg   <= local_port;
            rq_rp_reg   <= remote_port;
        end
        if (cmd.ent_lat)
        begin
            ent_lp_reg <= ent_rd.lp;
        end
        cmp_idx_reg <= scan_idx_reg[SW-1:0];
        for (int k = 0; k < 4; k++)
        begin
            if (cmp_live && match[k] && !hit_reg[k])
            begin
                hit_slot_reg[k] <= cmp_idx_reg;
            end
        end
        if (cmd.res_set)
        begin
            status_reg <= res_status;
            found_reg  <= res_found;
            given_reg  <= res_given;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg     <= RANGE_START_RST;
            end_reg       <= RANGE_END_RST;
            last_reg      <= RANGE_START_RST;
            valid_reg     <= '0;
            scan_idx_reg  <= '0;
            pend_reg      <= 1'b0;
            hit_reg       <= '0;
            cand_reg      <= RANGE_START_RST;
            iter_reg      <= 16'd0;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_RANGE_START)
                begin
                    start_reg <= cfg_data;
                end
                else
                begin
                    end_reg <= cfg_data;
                end
            end
            if (cmd.clr_step)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (cmd.valid_set)
            begin
                valid_reg[slot_addr] <= 1'b1;
            end
            if (cmd.valid_clr)
            begin
                valid_reg[slot_addr] <= 1'b0;
            end
            pend_reg <= cmd.scan_issue;
            if (cmd.scan_start)
            begin
                scan_idx_reg <= '0;
                hit_reg      <= '0;
            end
            else
            begin
                if (cmd.scan_issue)
                begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
                if (cmp_live)
                begin
                    hit_reg <= hit_reg | match;
                end
            end
            if (cmd.alloc_init)
            begin
                cand_reg <= init_cand;
                iter_reg <= 16'd0;
            end
            else if (cmd.alloc_adv)
            begin
                cand_reg <= adv_cand;
                iter_reg <= iter_reg + 16'd1;
            end
            if (cmd.res_set && cmd.res_kind == RES_GIVEN)
            begin
                last_reg <= cand_reg;
            end
            if (cmd.res_set)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        sts             = '0;
        sts.req_type    = rq_type_reg;
        sts.slot_ok     = slot_ok;
        sts.slot_vld    = slot_ok && valid_reg[slot_addr];
        sts.span_zero   = (span == 16'd0);
        sts.clr_done    = (clr_idx_reg == (PW+1)'(PORT_SLOTS));
        sts.scan_last   = (scan_idx_reg == (SW+1)'(CONN_SLOTS));
        sts.scan_done   = sts.scan_last && !pend_reg;
        sts.hit_exact   = hit_reg[0];
        sts.cnt_ok      = upd_port >= start_reg && upd_port < end_reg &&
                          {1'b0, upd_off} < 17'(PORT_SLOTS);
        sts.alloc_end   = (iter_reg == span);
        sts.cand_direct = ({1'b0, cand_off} >= 17'(PORT_SLOTS));
        sts.cnt_zero    = (cnt_rd_data == 7'd0);
        sts.out_free    = !out_valid_reg || !out_stall;
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign found_slot = found_reg;
    assign given_port = given_reg;

endmodule

// ===== rtl/tcp_socket_table_with_port_alloc_top.sv =====
// Socket table top level: lookup, insert and rekey run the one-read-per-cycle slot scan;
// remove reads only its own slot. Allocate reads the count memory once per port probed.
// One request is worked at a time; a finished result waits in an output register.
// After reset the port-count memory is cleared while in_stall is held high.
module tcp_socket_table_with_port_alloc_top
    import tcpst_pkg::*;
#(
    parameter int CONN_SLOTS = CONN_SLOTS_DEF,
    parameter int PORT_SLOTS = PORT_SLOTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         req_type,
    input  logic [5:0]         conn_slot,
    input  logic [31:0]        local_addr,
    input  logic [31:0]        remote_addr,
    input  logic [15:0]        local_port,
    input  logic signed [16:0] remote_port,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic [5:0]         found_slot,
    output logic [15:0]        given_port
);

    cmd_t cmd;
    sts_t sts;

    tcpst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    tcpst_dp #(.CONN_SLOTS(CONN_SLOTS), .PORT_SLOTS(PORT_SLOTS)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req_type    (req_type),
        .conn_slot   (conn_slot),
        .local_addr  (local_addr),
        .remote_addr (remote_addr),
        .local_port  (local_port),
        .remote_port (remote_port),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .found_slot  (found_slot),
        .given_port  (given_port),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the TCP socket table with ephemeral port allocation.
// Drives random and directed requests and checks each response against a built-in predictor.
// Depends on tcpst_pkg and tcp_socket_table_with_port_alloc_top.
module tb;
    import tcpst_pkg::*;

    typedef struct {
        bit [2:0]  kind;
        bit [5:0]  slot;
        bit [31:0] la;
        bit [31:0] ra;
        bit [15:0] lp;
        bit [16:0] rp;
    } request_t;

    typedef struct {
        bit [1:0]  status;
        bit [5:0]  slot;
        bit [15:0] port;
    } response_t;

    class socket_scoreboard;
        bit        used [64];
        bit [31:0] key_la [64];
        bit [31:0] key_ra [64];
        bit [15:0] key_lp [64];
        bit [16:0] key_rp [64];
        bit [6:0]  port_uses [4096];
        int        last_port;
        int        range_lo;
        int        range_hi;
        response_t pending [$];
        int        errs;

        function void clear();
            foreach (used[i]) used[i] = 0;
            foreach (port_uses[i]) port_uses[i] = 0;
            range_lo = RANGE_START_RST;
            range_hi = RANGE_END_RST;
            last_port = range_lo;
            errs = 0;
        endfunction

        function int find(bit [31:0] la, bit [31:0] ra, bit [15:0] lp, bit [16:0] rp,
                          int skip);
            for (int i = 0; i < 64; i++)
                if (i != skip && used[i] && key_la[i] == la && key_ra[i] == ra &&
                    key_lp[i] == lp && key_rp[i] == rp)
                    return i;
            return -1;
        endfunction

        function int port_offset(int port);
            if (port < range_lo || port >= range_hi || port - range_lo >= 4096)
                return -1;
            return port - range_lo;
        endfunction

        function void note(request_t r);
            response_t e;
            int hit;
            int off;
            int span;
            int cand;
            e.status = ST_NOT_FOUND;
            e.slot = 0;
            e.port = 0;
            case (r.kind)
                REQ_LOOKUP:
                begin
                    hit = find(r.la, r.ra, r.lp, r.rp, -1);
                    if (hit < 0) hit = find(0, r.ra, r.lp, r.rp, -1);
                    if (hit < 0) hit = find(r.la, 0, r.lp, ANY_PORT, -1);
                    if (hit < 0) hit = find(0, 0, r.lp, ANY_PORT, -1);
                    if (hit >= 0)
                    begin
                        e.status = ST_OK;
                        e.slot = 6'(hit);
                    end
                end
                REQ_INSERT:
                begin
                    if (used[r.slot] || find(r.la, r.ra, r.lp, r.rp, -1) >= 0)
                        e.status = ST_IN_USE;
                    else
                    begin
                        used[r.slot] = 1;
                        key_la[r.slot] = r.la;
                        key_ra[r.slot] = r.ra;
                        key_lp[r.slot] = r.lp;
                        key_rp[r.slot] = r.rp;
                        off = port_offset(r.lp);
                        if (off >= 0 && port_uses[off] < COUNT_MAX)
                            port_uses[off]++;
                        e.status = ST_OK;
                    end
                end
                REQ_REKEY:
                begin
                    if (used[r.slot])
                    begin
                        if (find(r.la, r.ra, key_lp[r.slot], r.rp, r.slot) >= 0)
                            e.status = ST_IN_USE;
                        else
                        begin
                            key_la[r.slot] = r.la;
                            key_ra[r.slot] = r.ra;
                            key_rp[r.slot] = r.rp;
                            e.status = ST_OK;
                        end
                    end
                end
                REQ_REMOVE:
                begin
                    if (used[r.slot])
                    begin
                        used[r.slot] = 0;
                        off = port_offset(key_lp[r.slot]);
                        if (off >= 0 && port_uses[off] != 0)
                            port_uses[off]--;
                        e.status = ST_OK;
                    end
                end
                REQ_ALLOC:
                begin
                    span = range_hi > range_lo ? range_hi - range_lo : 0;
                    cand = last_port + 1;
                    e.status = ST_EXHAUSTED;
                    if (cand >= range_hi || cand < range_lo)
                        cand = range_lo;
                    for (int i = 0; i < span; i++)
                    begin
                        if (cand - range_lo >= 4096 || port_uses[cand - range_lo] == 0)
                        begin
                            last_port = cand;
                            e.port = 16'(cand);
                            e.status = ST_OK;
                            break;
                        end
                        cand++;
                        if (cand >= range_hi)
                            cand = range_lo;
                    end
                end
                default: ;
            endcase
            pending.push_back(e);
        endfunction

        function void check(bit [1:0] st, bit [5:0] sl, bit [15:0] gp);
            response_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected response status=%0d", st);
                errs++;
                return;
            end
            e = pending.pop_front();
            if (st != e.status)
            begin
                $error("status expected %0d actual %0d", e.status, st);
                errs++;
            end
            if (sl != e.slot)
            begin
                $error("found_slot expected %0d actual %0d", e.slot, sl);
                errs++;
            end
            if (gp != e.port)
            begin
                $error("given_port expected %0d actual %0d", e.port, gp);
                errs++;
            end
        endfunction
    endclass

    logic               clk = 0;
    logic               rst_n = 0;
    logic               cfg_we = 0;
    logic               cfg_index = 0;
    logic [15:0]        cfg_data = 0;
    logic               in_valid = 0;
    logic               in_stall;
    logic [2:0]         req_type = 0;
    logic [5:0]         conn_slot = 0;
    logic [31:0]        local_addr = 0;
    logic [31:0]        remote_addr = 0;
    logic [15:0]        local_port = 0;
    logic signed [16:0] remote_port = 0;
    logic               out_valid;
    logic               out_stall = 0;
    logic [1:0]         status;
    logic [5:0]         found_slot;
    logic [15:0]        given_port;

    socket_scoreboard sb = new();
    int  send_gap_max = 11;
    int  recv_gap_max = 11;
    int  recv_wait = 0;
    int  quiet_cycles = 0;
    bit  [31:0] addr_pool [4] = '{32'hC0A8_0001, 32'h0A00_0002, 32'hFFFF_FFFF, 32'h7F00_0001};

    tcp_socket_table_with_port_alloc_top dut (.*);

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            sb.check(status, found_slot, given_port);
            recv_wait = $urandom_range(recv_gap_max, 0);
        end
        if ((out_valid && !out_stall) || (in_valid && !in_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= 30000)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (recv_wait > 0)
        begin
            out_stall <= 1;
            recv_wait--;
        end
        else
            out_stall <= 0;
    end

    task automatic send(request_t r);
        int gap;
        gap = $urandom_range(send_gap_max, 0);
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(negedge clk);
        end
        req_type <= r.kind;
        conn_slot <= r.slot;
        local_addr <= r.la;
        remote_addr <= r.ra;
        local_port <= r.lp;
        remote_port <= r.rp;
        in_valid <= 1;
        do
            @(posedge clk);
        while (in_stall);
        sb.note(r);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic set_range(int lo, int hi);
        cfg_we <= 1;
        cfg_index <= CFG_RANGE_START;
        cfg_data <= 16'(lo);
        @(negedge clk);
        cfg_index <= CFG_RANGE_END;
        cfg_data <= 16'(hi);
        @(negedge clk);
        cfg_we <= 0;
        sb.range_lo = lo;
        sb.range_hi = hi;
    endtask

    function automatic request_t make(bit [2:0] k, bit [5:0] s, bit [31:0] la, bit [31:0] ra,
                                      bit [15:0] lp, bit [16:0] rp);
        request_t r;
        r.kind = k;
        r.slot = s;
        r.la = la;
        r.ra = ra;
        r.lp = lp;
        r.rp = rp;
        return r;
    endfunction

    function automatic bit [31:0] pick_addr();
        case ($urandom_range(3, 0))
            0: return 0;
            3: return $urandom();
            default: return addr_pool[$urandom_range(3, 0)];
        endcase
    endfunction

    function automatic bit [15:0] pick_port();
        int span;
        span = sb.range_hi - sb.range_lo;
        if (span > 0 && $urandom_range(2, 0) != 0)
            return 16'(sb.range_lo + $urandom_range(span > 12 ? 11 : span - 1, 0));
        return $urandom_range(1, 0) ? 16'(80 + $urandom_range(2, 0)) : 16'($urandom());
    endfunction

    function automatic bit [16:0] pick_rport();
        case ($urandom_range(3, 0))
            0: return ANY_PORT;
            1: return 17'($urandom_range(65535, 0));
            default: return 17'(1000 + $urandom_range(3, 0));
        endcase
    endfunction

    function automatic request_t random_request();
        request_t r;
        int s;
        int roll;
        r = make(REQ_LOOKUP, 6'($urandom()), pick_addr(), pick_addr(), pick_port(),
                 pick_rport());
        roll = $urandom_range(99, 0);
        if (roll < 30)
        begin
            s = $urandom_range(63, 0);
            if (sb.used[s] && $urandom_range(2, 0) != 0)
            begin
                r.la = $urandom_range(3, 0) == 0 ? pick_addr() : sb.key_la[s];
                r.ra = $urandom_range(3, 0) == 0 ? pick_addr() : sb.key_ra[s];
                r.lp = sb.key_lp[s];
                r.rp = $urandom_range(3, 0) == 0 ? pick_rport() : sb.key_rp[s];
            end
        end
        else if (roll < 65)
            r.kind = REQ_INSERT;
        else if (roll < 75)
            r.kind = REQ_REKEY;
        else if (roll < 88)
            r.kind = REQ_REMOVE;
        else if (roll < 98)
            r.kind = REQ_ALLOC;
        else
            r.kind = 3'($urandom_range(7, 5));
        return r;
    endfunction

    initial
    begin
        static int los [6] = '{1024, 1000, 0, 65535, 60000, 200};
        static int his [6] = '{5000, 1008, 65535, 0, 60016, 200};
        sb.clear();
        repeat (2) @(negedge clk);
        rst_n = 1;

        send(make(REQ_LOOKUP, 0, 0, 0, 0, 0));
        send(make(REQ_INSERT, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 17'h0FFFF));
        send(make(REQ_INSERT, 0, 1, 2, 3, 4));
        send(make(REQ_INSERT, 63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 17'h0FFFF));
        send(make(REQ_INSERT, 1, 0, 32'h0A00_0002, 1024, 1000));
        send(make(REQ_INSERT, 2, 32'hC0A8_0001, 0, 1024, ANY_PORT));
        send(make(REQ_INSERT, 3, 0, 0, 1024, ANY_PORT));
        send(make(REQ_INSERT, 63, 0, 0, 0, 0));
        send(make(REQ_LOOKUP, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 17'h0FFFF));
        send(make(REQ_LOOKUP, 0, 32'hC0A8_0001, 32'h0A00_0002, 1024, 1000));
        send(make(REQ_LOOKUP, 0, 32'hC0A8_0001, 32'h0B00_0002, 1024, 7));
        send(make(REQ_LOOKUP, 0, 32'h0, 32'h0B00_0002, 1024, 7));
        send(make(REQ_REKEY, 63, 0, 32'h0A00_0002, 0, 1000));
        send(make(REQ_REKEY, 3, 5, 6, 0, 7));
        send(make(REQ_REKEY, 3, 32'hC0A8_0001, 0, 0, ANY_PORT));
        send(make(REQ_REKEY, 10, 5, 6, 0, 7));
        send(make(REQ_REMOVE, 10, 0, 0, 0, 0));
        send(make(REQ_REMOVE, 1, 0, 0, 0, 0));
        send(make(REQ_ALLOC, 0, 0, 0, 0, 0));
        send(make(REQ_ALLOC, 0, 0, 0, 0, 0));
        send(make(3'd5, 0, 0, 0, 0, 0));
        send(make(3'd7, 63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, ANY_PORT));

        for (int ph = 0; ph < 6; ph++)
        begin
            drain();
            set_range(los[ph], his[ph]);
            send_gap_max = ph == 4 ? 0 : 11;
            recv_gap_max = ph == 2 ? 0 : 11;
            for (int n = 0; n < 150; n++)
            begin
                if (n == 60)
                    drain();
                send(random_request());
            end
        end

        drain();
        set_range(RANGE_START_RST, RANGE_END_RST);
        drain();
        repeat (100) @(posedge clk);
        if (sb.errs == 0 && sb.pending.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
